// ===== src/hubl_pkg.sv =====
// Package for the hold upsampler with Bessel low-pass filter.
// Holds fixed-point widths, filter coefficients and shared arithmetic helpers.
// No dependencies.
package hubl_pkg;

  localparam int UPSAMPLE_FACTOR = 3;
  localparam int SLOT_W = $clog2(UPSAMPLE_FACTOR);
  localparam int NTAPS = 4;

  localparam int SAMPLE_W = 16;
  localparam int XW = 27;        // scaled input, Q12
  localparam int YW = 32;        // filter output state, Q12
  localparam int CW = 18;        // feedback coefficient, Q2.16
  localparam int WW = 3;         // feedforward binomial weight
  localparam int FFW = XW + WW + 1;
  localparam int FBW = YW + CW;
  localparam int FB_SUM_W = FBW + 2;
  localparam int FB_SH = 16;
  localparam int YWIDE_W = FB_SUM_W - FB_SH + 1;
  localparam int Q_SH = 12;

  localparam logic signed [SAMPLE_W:0] IN_GAIN = 17'sd19319;

  typedef logic signed [CW-1:0] coef_t;
  typedef logic [WW-1:0] weight_t;

  // Tap k holds x[n-1-k] and y[n-1-k].
  localparam coef_t FB_COEF [NTAPS] = '{
    -18'sd129009, -18'sd104107, -18'sd39084, -18'sd5708
  };
  localparam weight_t FF_WEIGHT [NTAPS] = '{3'd4, 3'd6, 3'd4, 3'd1};

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

  // floor(sample * gain / 16)
  function automatic logic signed [XW-1:0] scale_sample(logic signed [SAMPLE_W-1:0] s);
    logic signed [2*SAMPLE_W:0] p;
    p = (2*SAMPLE_W+1)'(s) * (2*SAMPLE_W+1)'(IN_GAIN);
    return p[XW+3:4];
  endfunction

  function automatic logic signed [YW-1:0] sat_y(logic signed [YWIDE_W-1:0] v);
    logic signed [YWIDE_W-1:0] hi;
    logic signed [YWIDE_W-1:0] lo;
    hi = YWIDE_W'({1'b0, {(YW-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[YW-1:0];
    if (v < lo) return lo[YW-1:0];
    return v[YW-1:0];
  endfunction

  // y / 4096 truncated toward zero, clamped to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] quant_out(logic signed [YW-1:0] y);
    logic signed [YW:0] t;
    logic signed [YW:0] q;
    t = (YW+1)'(y);
    if (y < 0) t = t + (YW+1)'((1 << Q_SH) - 1);
    q = t >>> Q_SH;
    if (q > (YW+1)'(32767)) return 16'sh7fff;
    if (q < -(YW+1)'(32768)) return 16'sh8000;
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== src/hubl_tap_cell.sv =====
// One delay tap of the filter: holds one input and one output history word.
// Shifts both to the next tap on each step and offers its weighted terms.
// Depends on hubl_pkg.
module hubl_tap_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hubl_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [hubl_pkg::XW-1:0]   x_i,
  input  logic signed [hubl_pkg::YW-1:0]   y_i,
  input  hubl_pkg::coef_t                  coef_i,
  input  hubl_pkg::weight_t                weight_i,
  output logic signed [hubl_pkg::XW-1:0]   x_o,
  output logic signed [hubl_pkg::YW-1:0]   y_o,
  output logic signed [hubl_pkg::FFW-1:0]  ff_o,
  output logic signed [hubl_pkg::FBW-1:0]  fb_o
);
  import hubl_pkg::*;

  logic signed [XW-1:0] x_q, x_d;
  logic signed [YW-1:0] y_q, y_d;

  assign x_d = ctrl_i.shift ? x_i : x_q;
  assign y_d = ctrl_i.shift ? y_i : y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o  = x_q;
  assign y_o  = y_q;
  assign ff_o = x_q * $signed({1'b0, weight_i});
  assign fb_o = y_q * coef_i;

endmodule

// ===== src/hold_upsample_bessel_lowpass.sv =====
// Top level: 3x hold upsampler feeding a fourth-order Bessel IIR low-pass.
// Depends on hubl_pkg and hubl_tap_cell.
//
// Channel  Dir  Payload                                  Transaction
// s_axis   in   tdata = sample_in[15:0], tuser = mode    tvalid & tready
// m_axis   out  tdata = filtered_out[15:0], tlast=last   tvalid & tready
//
// A sample item runs one filter step per held slot, a silence item runs a
// single step. The y[n] -> y[n+1] feedback through the tap chain keeps
// the steps serial: each step needs the output of the step before it.
// A new item is taken in the cycle its predecessor runs its final step.
// Reset clears the tap histories and all control; there is no clearing pass.
// Output stalls hold the current step; the result register parts the sides.
module hold_upsample_bessel_lowpass (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample_in
  input  logic        s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] filtered_out
  output logic        m_axis_tlast_o
);
  import hubl_pkg::*;

  // held item
  logic                    hold_valid_q, hold_valid_d;
  logic [SLOT_W-1:0]       slots_q, slots_d;     // steps remaining after this one
  logic signed [XW-1:0]    hold_x_q, hold_x_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic                    out_last_q, out_last_d;
  logic signed [YW-1:0]    out_y_q, out_y_d;

  logic s_accept, step, last_step;
  cell_ctrl_t cell_ctrl;

  // tap chain wiring
  logic signed [XW-1:0]  x_chain  [NTAPS];
  logic signed [YW-1:0]  y_chain  [NTAPS];
  logic signed [FFW-1:0] ff_term  [NTAPS];
  logic signed [FBW-1:0] fb_term  [NTAPS];

  logic signed [FFW-1:0]      ff_sum;
  logic signed [FB_SUM_W-1:0] fb_sum;
  logic signed [YWIDE_W-1:0]  y_wide;
  logic signed [YW-1:0]       y_new;

  // a step runs when an item is held and the result slot is free or draining
  assign step      = hold_valid_q && (!out_valid_q || m_axis_tready_i);
  assign last_step = step && (slots_q == '0);
  assign s_axis_tready_o = !hold_valid_q || last_step;
  assign s_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign cell_ctrl.shift = step;

  always_comb begin
    hold_valid_d = hold_valid_q;
    slots_d      = slots_q;
    hold_x_d     = hold_x_q;
    if (s_accept) begin
      hold_valid_d = 1'b1;
      // silence: one zero slot; sample: scale once, hold for all slots
      slots_d  = s_axis_tuser_i ? '0 : SLOT_W'(UPSAMPLE_FACTOR - 1);
      hold_x_d = s_axis_tuser_i ? '0 : scale_sample($signed(s_axis_tdata_i));
    end else if (last_step) begin
      hold_valid_d = 1'b0;
    end else if (step) begin
      slots_d = slots_q - SLOT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_y_d     = out_y_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_last_d  = (slots_q == '0);
      out_y_d     = y_new;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      slots_q      <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      slots_q      <= slots_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_x_q <= hold_x_d;
    out_y_q  <= out_y_d;
  end

  // chain of taps: tap 0 takes the current step's x and y
  for (genvar k = 0; k < NTAPS; k++) begin : g_tap
    logic signed [XW-1:0] x_in;
    logic signed [YW-1:0] y_in;
    if (k == 0) begin : g_head
      assign x_in = hold_x_q;
      assign y_in = y_new;
    end else begin : g_body
      assign x_in = x_chain[k-1];
      assign y_in = y_chain[k-1];
    end
    hubl_tap_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .x_i      (x_in),
      .y_i      (y_in),
      .coef_i   (FB_COEF[k]),
      .weight_i (FF_WEIGHT[k]),
      .x_o      (x_chain[k]),
      .y_o      (y_chain[k]),
      .ff_o     (ff_term[k]),
      .fb_o     (fb_term[k])
    );
  end

  // ff*65536 is exact, so floor(acc/65536) = ff + floor(fb/65536)
  always_comb begin
    ff_sum = FFW'(hold_x_q);
    fb_sum = '0;
    for (int k = 0; k < NTAPS; k++) begin
      ff_sum = ff_sum + ff_term[k];
      fb_sum = fb_sum + FB_SUM_W'(fb_term[k]);
    end
    y_wide = YWIDE_W'(ff_sum) + YWIDE_W'(fb_sum >>> FB_SH);
    y_new  = sat_y(y_wide);
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = quant_out(out_y_q);

  // a held item with steps left never lets a new one in
  a_no_accept_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && !last_step) |-> !s_axis_tready_o)
    else $error("input taken while item still has steps");

  // a sample transaction starts a full run of slots
  a_sample_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !s_axis_tuser_i) |=>
      (hold_valid_q && slots_q == SLOT_W'(UPSAMPLE_FACTOR - 1)))
    else $error("sample run not loaded");

  // every step lands in the result register, flagged last on its final slot
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (m_axis_tvalid_o && (m_axis_tlast_o == $past(slots_q == '0))))
    else $error("step result lost or mis-flagged");

  // taps only move when a step runs
  a_tap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(y_chain[0]))
    else $error("tap history moved without a step");

endmodule
